>>> hw/rtl/aoc_pkg.sv
package aoc_pkg;

  localparam int ADC_CHANNELS = 16;
  localparam int CH_W         = 4;
  localparam int PIX_W        = 12;
  localparam int OFF_W        = 11;
  localparam int OFFSET_LIMIT = 1023;

  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [CH_W-1:0]         ch_t;
  typedef logic signed [OFF_W-1:0] off_t;

  localparam pix_t MIN_RESET    = '1;
  localparam pix_t TARGET_RESET = PIX_W'(30);
  localparam ch_t  LAST_CH      = CH_W'(ADC_CHANNELS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic lt;
    off_t offset;
  } alu_res_t;

endpackage

>>> hw/rtl/aoc_pix_if.sv
interface aoc_pix_if;
  logic          valid;
  logic          ready;
  aoc_pkg::pix_t pixel;
  logic          row_end;

  modport source (output valid, output pixel, output row_end, input ready);
  modport sink (input valid, input pixel, input row_end, output ready);
endinterface

>>> hw/rtl/aoc_res_if.sv
interface aoc_res_if;
  logic          valid;
  logic          ready;
  aoc_pkg::ch_t  channel;
  aoc_pkg::off_t offset;
  logic          final_res;

  modport source (output valid, output channel, output offset, output final_res,
                  input ready);
  modport sink (input valid, input channel, input offset, input final_res,
                output ready);
endinterface

>>> hw/rtl/aoc_cfg_if.sv
interface aoc_cfg_if;
  logic          valid;
  logic          ready;
  aoc_pkg::pix_t black_target;

  modport source (output valid, output black_target, input ready);
  modport sink (input valid, input black_target, output ready);
endinterface

>>> hw/rtl/aoc_alu.sv
module aoc_alu (
  input  aoc_pkg::pix_t     a,
  input  aoc_pkg::pix_t     b,
  output aoc_pkg::alu_res_t res
);

  localparam logic signed [aoc_pkg::PIX_W:0] LIM_HI =
    (aoc_pkg::PIX_W+1)'(aoc_pkg::OFFSET_LIMIT);
  localparam logic signed [aoc_pkg::PIX_W:0] LIM_LO =
    (aoc_pkg::PIX_W+1)'(-aoc_pkg::OFFSET_LIMIT);

  logic signed [aoc_pkg::PIX_W:0] diff;
  logic signed [aoc_pkg::PIX_W:0] rnd;
  logic signed [aoc_pkg::PIX_W:0] quo;

  always_comb begin
    diff = $signed({1'b0, a}) - $signed({1'b0, b});
    // bias negatives by one so the shift truncates toward zero
    rnd  = diff + $signed({{aoc_pkg::PIX_W{1'b0}}, diff[aoc_pkg::PIX_W]});
    quo  = rnd >>> 1;
    res.lt = diff[aoc_pkg::PIX_W];
    if (quo > LIM_HI) begin
      res.offset = aoc_pkg::off_t'(aoc_pkg::OFFSET_LIMIT);
    end else if (quo < LIM_LO) begin
      res.offset = aoc_pkg::off_t'(-aoc_pkg::OFFSET_LIMIT);
    end else begin
      res.offset = quo[aoc_pkg::OFF_W-1:0];
    end
  end

endmodule

>>> hw/rtl/adc_offset_calibration.sv
// channel  dir   beat                               handshake
// in_if    sink  pixel[11:0], row_end               valid/ready
// out_if   src   channel[3:0], offset[10:0] signed, final_res  valid/ready
// cfg_if   sink  black_target[11:0]                 valid/ready, always ready
//
// Pixels go in back to back; ready is high whenever no row is being reported.
// A row-end pixel starts 16 results, each through ST_CALC then ST_OUT, where
// it waits out output stalls; all come from one shared subtract/shift/clamp unit.
// Reset (rst_n, synchronous): minima read as 4095, column 0, target 30.
// Input is held off while results drain; the output register holds on stall.
module adc_offset_calibration (
  input logic            clk,
  input logic            rst_n,
  aoc_pix_if.sink        in_if,
  aoc_res_if.source      out_if,
  aoc_cfg_if.sink        cfg_if
);

  aoc_pkg::state_t   state_r;
  aoc_pkg::state_t   state_nxt;
  aoc_pkg::pix_t     target_r;
  aoc_pkg::ch_t      col_r;
  aoc_pkg::ch_t      idx_r;
  aoc_pkg::pix_t     min_r [aoc_pkg::ADC_CHANNELS];
  logic [aoc_pkg::ADC_CHANNELS-1:0] vld_r;
  aoc_pkg::ch_t      out_ch_r;
  aoc_pkg::off_t     out_off_r;
  logic              out_fin_r;

  aoc_pkg::ch_t      rd_addr;
  aoc_pkg::pix_t     rd_min;
  aoc_pkg::pix_t     alu_a;
  aoc_pkg::alu_res_t alu_res;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  always_comb begin
    rd_addr = (state_r == aoc_pkg::ST_IDLE) ? col_r : idx_r;
    rd_min  = vld_r[rd_addr] ? min_r[rd_addr] : aoc_pkg::MIN_RESET;
    alu_a   = (state_r == aoc_pkg::ST_IDLE) ? in_if.pixel : target_r;
  end

  aoc_alu u_alu (
    .a   (alu_a),
    .b   (rd_min),
    .res (alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aoc_pkg::ST_IDLE: begin
        if (in_acc && in_if.row_end) state_nxt = aoc_pkg::ST_CALC;
      end
      aoc_pkg::ST_CALC: begin
        state_nxt = aoc_pkg::ST_OUT;
      end
      aoc_pkg::ST_OUT: begin
        if (out_acc) state_nxt = out_fin_r ? aoc_pkg::ST_IDLE : aoc_pkg::ST_CALC;
      end
      default: state_nxt = aoc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready  = (state_r == aoc_pkg::ST_IDLE);
    out_if.valid = (state_r == aoc_pkg::ST_OUT);
  end

  assign cfg_if.ready     = 1'b1;
  assign out_if.channel   = out_ch_r;
  assign out_if.offset    = out_off_r;
  assign out_if.final_res = out_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= aoc_pkg::ST_IDLE;
      target_r <= aoc_pkg::TARGET_RESET;
      col_r    <= '0;
      idx_r    <= '0;
      vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid) begin
        target_r <= cfg_if.black_target;
      end
      if (in_acc) begin
        col_r <= (col_r == aoc_pkg::LAST_CH) ? '0 : col_r + 1'b1;
        if (alu_res.lt) begin
          vld_r[col_r] <= 1'b1;
        end
      end
      if ((state_r == aoc_pkg::ST_OUT) && out_acc) begin
        if (out_fin_r) begin
          idx_r <= '0;
          col_r <= '0;
          vld_r <= '0;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && alu_res.lt) begin
      min_r[col_r] <= in_if.pixel;
    end
    if (state_r == aoc_pkg::ST_CALC) begin
      out_ch_r  <= idx_r;
      out_off_r <= alu_res.offset;
      out_fin_r <= (idx_r == aoc_pkg::LAST_CH);
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> !out_if.valid)
    else $error("input ready while results pending");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.final_res) |-> (out_if.channel == aoc_pkg::LAST_CH))
    else $error("final result on wrong channel");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.ready && out_if.final_res) |=>
      (col_r == '0 && vld_r == '0 && idx_r == '0))
    else $error("row state not cleared");

  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.offset != aoc_pkg::off_t'(-aoc_pkg::OFFSET_LIMIT - 1)))
    else $error("offset outside clamp range");
`endif

endmodule

>>> verif/adc_offset_calibration_checker.sv
`timescale 1ns / 1ps
module adc_offset_calibration_checker
  import aoc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  aoc_pix_if   pix,
  aoc_res_if   res,
  aoc_cfg_if   cfg,
  output int   errors,
  output int   n_pending
);

  typedef struct {
    ch_t  channel;
    off_t offset;
    logic final_res;
  } ch_offset_t;

  ch_offset_t offset_q[$];
  pix_t       chan_min[ADC_CHANNELS];
  ch_t        col_chan;
  pix_t       target;

  function automatic off_t calib_offset(pix_t tgt, pix_t minimum);
    int diff;
    int quot;
    diff = int'(tgt) - int'(minimum);
    quot = diff / 2;
    if (quot > OFFSET_LIMIT) quot = OFFSET_LIMIT;
    if (quot < -OFFSET_LIMIT) quot = -OFFSET_LIMIT;
    return off_t'(quot);
  endfunction

  task automatic log_miss(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic clear_row();
    foreach (chan_min[k]) chan_min[k] = MIN_RESET;
    col_chan = '0;
  endtask

  always @(posedge clk) begin : watch
    ch_offset_t want;
    if (!rst_n) begin
      target = TARGET_RESET;
      clear_row();
      offset_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (offset_q.size() == 0) begin
          log_miss($sformatf("result beat ch %0d off %0d with nothing expected",
                             res.channel, res.offset));
        end else begin
          want = offset_q.pop_front();
          if (res.channel !== want.channel)
            log_miss($sformatf("channel got %0d want %0d", res.channel, want.channel));
          if (res.offset !== want.offset)
            log_miss($sformatf("ch %0d offset got %0d want %0d",
                               want.channel, res.offset, want.offset));
          if (res.final_res !== want.final_res)
            log_miss($sformatf("ch %0d final_res got %b want %b",
                               want.channel, res.final_res, want.final_res));
        end
      end
      if (cfg.valid && cfg.ready) target = cfg.black_target;
      if (pix.valid && pix.ready) begin
        if (pix.pixel < chan_min[col_chan]) chan_min[col_chan] = pix.pixel;
        col_chan = (col_chan == LAST_CH) ? '0 : col_chan + 1'b1;
        if (pix.row_end) begin
          for (int k = 0; k < ADC_CHANNELS; k++) begin
            want.channel   = ch_t'(k);
            want.offset    = calib_offset(target, chan_min[k]);
            want.final_res = (k == ADC_CHANNELS - 1);
            offset_q.push_back(want);
          end
          clear_row();
        end
      end
    end
    n_pending <= offset_q.size();
  end

endmodule

>>> verif/adc_offset_calibration_tb.sv
`timescale 1ns / 1ps
module adc_offset_calibration_tb;
  import aoc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_GOAL   = 220;
  localparam int DRAIN_TAIL  = 8;
  localparam int END_TAIL    = 40;

  logic clk;
  logic rst_n;
  int   src_idle = 17;
  int   snk_idle = 48;
  int   cycles;
  int   errors;
  int   n_pending;
  int   sent;
  pix_t cur_target;

  aoc_pix_if pix_bus();
  aoc_res_if res_bus();
  aoc_cfg_if cfg_bus();

  adc_offset_calibration dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (pix_bus),
    .out_if (res_bus),
    .cfg_if (cfg_bus)
  );

  adc_offset_calibration_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix       (pix_bus),
    .res       (res_bus),
    .cfg       (cfg_bus),
    .errors    (errors),
    .n_pending (n_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("adc_offset_calibration_tb: errors");
      $finish;
    end
  end

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_bus.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic push_pixel(input pix_t value, input logic last);
    while ($urandom_range(99) < src_idle) begin
      pix_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pix_bus.valid   <= 1'b1;
    pix_bus.pixel   <= value;
    pix_bus.row_end <= last;
    do @(posedge clk); while (!pix_bus.ready);
    sent++;
  endtask

  // hold input until every offset of the row has drained
  task automatic drain_rows();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_target(input pix_t value);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.black_target <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cur_target = value;
  endtask

  function automatic pix_t pick_pixel(input pix_t tgt);
    int roll;
    int val;
    roll = $urandom_range(99);
    if (roll < 40) return pix_t'($urandom_range(4095));
    if (roll < 70) return pix_t'($urandom_range(63));
    if (roll < 90) begin
      val = int'($urandom_range(80)) - 40 + int'(tgt);
      if (val < 0) val = 0;
      if (val > 4095) val = 4095;
      return pix_t'(val);
    end
    return $urandom_range(1) ? MIN_RESET : pix_t'(0);
  endfunction

  task automatic send_row(input int len);
    for (int i = 0; i < len; i++) push_pixel(pick_pixel(cur_target), i == len - 1);
  endtask

  initial begin
    pix_t dark_row[18];
    int   len;
    dark_row = '{12'd4095, 12'd33, 12'd31, 12'd30, 12'd29, 12'd0, 12'd4094, 12'd2048,
                 12'd1, 12'd4095, 12'd100, 12'd60, 12'd27, 12'd3000, 12'd15, 12'd1000,
                 12'd500, 12'd32};
    pix_bus.valid        <= 1'b0;
    pix_bus.pixel        <= '0;
    pix_bus.row_end      <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.black_target <= '0;
    rst_n                <= 1'b0;
    cur_target = TARGET_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_pixel('0, 1'b1);
    drain_rows();
    foreach (dark_row[i]) push_pixel(dark_row[i], i == 17);
    drain_rows();
    write_target(MIN_RESET);
    push_pixel('0, 1'b1);
    drain_rows();
    write_target('0);
    push_pixel(MIN_RESET, 1'b1);
    drain_rows();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 17 : (ph == 1) ? 48 : 0;
      snk_idle = (ph == 0) ? 48 : (ph == 1) ? 17 : 0;
      write_target(pix_t'($urandom_range(4095)));
      while (sent < 21 + ITEM_GOAL * (ph + 1) / 3) begin
        len = ($urandom_range(9) < 8) ? $urandom_range(1, 40) : $urandom_range(41, 70);
        send_row(len);
        if ($urandom_range(3) == 0) drain_rows();
      end
      drain_rows();
    end

    repeat (END_TAIL) @(posedge clk);
    if (errors == 0 && n_pending == 0)
      $display("adc_offset_calibration_tb: clean");
    else
      $display("adc_offset_calibration_tb: errors");
    $finish;
  end

endmodule
